### sv/assert_macros.svh
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("%m failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

### sv/ktc_pkg.sv
`default_nettype none
package ktc_pkg;
	localparam int WIN_LEN = 13;
	localparam int N_KEYS = 40;
	localparam int N_GRP = 10;

	typedef logic [7:0] byte_t;
	typedef logic [WIN_LEN*8-1:0] key_text_t;

	typedef struct packed {
		key_text_t txt;
		logic [3:0] len;
		logic [3:0] grp;
	} key_t;

	localparam logic REG_SESSION = 1'b0;
	localparam logic REG_MIN_CONF = 1'b1;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_NO_CAND = 3'd1;
	localparam logic [2:0] ST_BAD_CONF = 3'd2;
	localparam logic [2:0] ST_TOO_LONG = 3'd3;
	localparam logic [2:0] ST_BAD_SESS = 3'd4;

	localparam logic [2:0] K_NONE = 3'd0;
	localparam logic [2:0] K_IDEA = 3'd1;
	localparam logic [2:0] K_DECISION = 3'd2;
	localparam logic [2:0] K_COMMIT = 3'd3;
	localparam logic [2:0] K_PREF = 3'd4;
	localparam logic [2:0] K_PROJECT = 3'd5;
	localparam logic [2:0] K_ROUTINE = 3'd6;

	localparam logic [3:0] G_EXPL = 4'd0;
	localparam logic [3:0] G_DECIDE = 4'd1;
	localparam logic [3:0] G_COMMIT = 4'd2;
	localparam logic [3:0] G_IDEA = 4'd3;
	localparam logic [3:0] G_PREF = 4'd4;
	localparam logic [3:0] G_PROJ = 4'd5;
	localparam logic [3:0] G_ROUTINE = 4'd6;
	localparam logic [3:0] G_OTHER = 4'd7;
	localparam logic [3:0] G_SELF = 4'd8;
	localparam logic [3:0] G_SENS = 4'd9;

	localparam logic [1:0] ORG_NONE = 2'd0;
	localparam logic [1:0] ORG_EXPLICIT = 2'd1;
	localparam logic [1:0] ORG_INFER = 2'd2;

	localparam logic [1:0] SC_SELF = 2'd0;
	localparam logic [1:0] SC_OTHER = 2'd1;
	localparam logic [1:0] SC_MIXED = 2'd2;

	// keyword text, first char in the low byte
	function automatic key_t mk(input string s, input logic [3:0] g);
		key_t k;
		k.txt = '0;
		for (int i = 0; i < s.len(); i++) k.txt[i*8 +: 8] = s[i];
		k.len = 4'(s.len());
		k.grp = g;
		return k;
	endfunction

	function automatic key_t key_at(input int i);
		key_t k;
		unique case (i)
			0: k = mk("lembre", G_EXPL);   1: k = mk("guarde", G_EXPL);
			2: k = mk("anote", G_EXPL);    3: k = mk("decidimos", G_DECIDE);
			4: k = mk("decidi", G_DECIDE); 5: k = mk("vamos", G_DECIDE);
			6: k = mk("eu vou", G_COMMIT); 7: k = mk("me comprometo", G_COMMIT);
			8: k = mk("combino", G_COMMIT); 9: k = mk("ideia", G_IDEA);
			10: k = mk("pensei", G_IDEA);  11: k = mk("imagino", G_IDEA);
			12: k = mk("prefiro", G_PREF); 13: k = mk("nao gosto", G_PREF);
			14: k = mk("gosto de", G_PREF); 15: k = mk({"he", "rus"}, G_PROJ);
			16: k = mk("nucleo", G_PROJ);  17: k = mk("projeto", G_PROJ);
			18: k = mk("costumo", G_ROUTINE); 19: k = mk("sempre levo", G_ROUTINE);
			20: k = mk("minha rotina", G_ROUTINE); 21: k = mk("ele ", G_OTHER);
			22: k = mk("ela ", G_OTHER);    23: k = mk("outra pessoa", G_OTHER);
			24: k = mk("meu amigo", G_OTHER); 25: k = mk("minha amiga", G_OTHER);
			26: k = mk("minha mae", G_OTHER); 27: k = mk("meu pai", G_OTHER);
			28: k = mk(" eu ", G_SELF);    29: k = mk(" meu ", G_SELF);
			30: k = mk(" minha ", G_SELF); 31: k = mk(" comigo", G_SELF);
			32: k = mk("medico", G_SENS);  33: k = mk("saude", G_SENS);
			34: k = mk("financeiro", G_SENS); 35: k = mk("juridico", G_SENS);
			36: k = mk("senha", G_SENS);   37: k = mk("endereco", G_SENS);
			38: k = mk("localizacao", G_SENS);
			default: k = mk("intimo", G_SENS);
		endcase
		return k;
	endfunction

	// novelty, future value, consequence per kind
	function automatic logic [20:0] kind_defaults(input logic [2:0] kind);
		logic [20:0] d;
		unique case (kind)
			K_IDEA: d = {7'd75, 7'd90, 7'd45};
			K_DECISION: d = {7'd70, 7'd90, 7'd70};
			K_COMMIT: d = {7'd60, 7'd85, 7'd85};
			K_PREF: d = {7'd50, 7'd65, 7'd35};
			K_PROJECT: d = {7'd50, 7'd75, 7'd50};
			K_ROUTINE: d = {7'd55, 7'd70, 7'd30};
			default: d = '0;
		endcase
		return d;
	endfunction
endpackage
`default_nettype wire

### sv/ktc_cell.sv
`default_nettype none
// one window byte; hands its byte to the next cell on every shift
module ktc_cell (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic shift,
	input wire logic clear,
	input wire ktc_pkg::byte_t din,
	output ktc_pkg::byte_t dout
);
	ktc_pkg::byte_t byte_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) byte_q <= '0;
		else if (shift) byte_q <= clear ? '0 : din;
	end
	assign dout = byte_q;
endmodule
`default_nettype wire

### sv/ktc_match.sv
`default_nettype none
// parallel keyword compare against window tail, one hit bit per group
module ktc_match (
	input wire logic [ktc_pkg::WIN_LEN*8-1:0] win,
	output logic [ktc_pkg::N_GRP-1:0] hits
);
	always_comb begin
		ktc_pkg::key_t k;
		logic ok;
		hits = '0;
		for (int i = 0; i < ktc_pkg::N_KEYS; i++) begin
			k = ktc_pkg::key_at(i);
			ok = 1'b1;
			for (int j = 0; j < ktc_pkg::WIN_LEN; j++)
				if (j < int'(k.len) &&
					win[(int'(k.len) - 1 - j)*8 +: 8] != k.txt[j*8 +: 8]) ok = 1'b0;
			if (ok) hits[k.grp] = 1'b1;
		end
	end
endmodule
`default_nettype wire

### sv/keyword_text_classifier.sv
// keyword text classifier
// in channel: in_valid/in_ready carry one text byte per request with last_char;
// session_id and confidence are read on the last byte only.
// out channel: out_valid/out_ready carry one result per text, after its last byte.
// cfg channel: cfg_valid/cfg_ready write expected_session (0) and
// the minimum confidence (1); always ready, write only while idle.
// one byte per cycle sustained; a result appears in the cycle after the last
// byte is accepted, from a single output register.
// the input stalls only while a result sits in the output register and the
// receiver is not taking it in the same cycle.
// the window is a row of thirteen byte cells shifting each accepted byte;
// all keywords compare against the incoming window in that same cycle.
// reset clears window, count, hits, output valid; min confidence goes to 60.
// after each last byte the window, count and hits clear for the next text.
`default_nettype none
`include "assert_macros.svh"
module keyword_text_classifier #(
	parameter int MAX_TEXT = 256
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [7:0] char_code,
	input wire logic last_char,
	input wire logic [31:0] session_id,
	input wire logic [7:0] confidence,
	output logic out_valid,
	input wire logic out_ready,
	output logic [2:0] status,
	output logic [2:0] kind,
	output logic [1:0] origin,
	output logic [9:0] reasons,
	output logic [6:0] novelty,
	output logic [6:0] future_value,
	output logic [6:0] consequence,
	output logic [1:0] scope,
	output logic sensitive,
	output logic remember_req,
	output logic [6:0] confidence_echo,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic cfg_index,
	input wire logic [31:0] cfg_data
);
	localparam int CW = $clog2(MAX_TEXT + 2);
	localparam int W = ktc_pkg::WIN_LEN;

	logic [31:0] exp_sess_q;
	logic [6:0] min_conf_q;
	logic [CW-1:0] count_q;
	logic [ktc_pkg::N_GRP-1:0] hits_q;
	logic take, tail_q;
	logic [W*8-1:0] win_now, win_cur;
	logic [ktc_pkg::N_GRP-1:0] hit_now, h;
	ktc_pkg::byte_t lc;
	logic [CW-1:0] cnt_n;

	assign cfg_ready = 1'b1;
	assign in_ready = !out_valid || out_ready;
	assign take = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_sess_q <= '0;
			min_conf_q <= 7'd60;
		end else if (cfg_valid) begin
			if (cfg_index == ktc_pkg::REG_MIN_CONF) min_conf_q <= cfg_data[6:0];
			else exp_sess_q <= cfg_data;
		end
	end

	assign lc = (char_code >= 8'h41 && char_code <= 8'h5a) ? char_code + 8'h20 : char_code;

	// incoming window: new byte in cell 0 position, cells shifted up
	assign win_now = {win_cur[(W-1)*8-1:0], lc};

	for (genvar g = 0; g < W; g++) begin : g_cell
		ktc_cell u_cell (
			.clk(clk), .arst_n(arst_n), .shift(take), .clear(last_char),
			.din(win_now[g*8 +: 8]), .dout(win_cur[g*8 +: 8])
		);
	end

	ktc_match u_match (.win(win_now), .hits(hit_now));

	assign h = hits_q | hit_now;
	assign cnt_n = (count_q <= CW'(MAX_TEXT)) ? count_q + 1'b1 : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			hits_q <= '0;
		end else if (take) begin
			count_q <= last_char ? '0 : cnt_n;
			hits_q <= last_char ? '0 : h;
		end
	end

	// result build
	logic [2:0] st_c, kd_c;
	logic [1:0] or_c, sc_c;
	logic [9:0] rs_c;
	logic sn_c, ex_c;
	logic [6:0] ec_c;
	always_comb begin
		kd_c = ktc_pkg::K_NONE; or_c = ktc_pkg::ORG_NONE; rs_c = '0;
		sc_c = ktc_pkg::SC_SELF; sn_c = 1'b0; ex_c = 1'b0;
		ec_c = '0; st_c = ktc_pkg::ST_OK;
		priority if (h[ktc_pkg::G_DECIDE]) begin
			kd_c = ktc_pkg::K_DECISION; rs_c[1] = 1'b1;
		end else if (h[ktc_pkg::G_COMMIT]) begin
			kd_c = ktc_pkg::K_COMMIT; rs_c[2] = 1'b1;
		end else if (h[ktc_pkg::G_IDEA]) begin
			kd_c = ktc_pkg::K_IDEA; rs_c[3] = 1'b1;
		end else if (h[ktc_pkg::G_PREF]) begin
			kd_c = ktc_pkg::K_PREF; rs_c[4] = 1'b1;
		end else if (h[ktc_pkg::G_PROJ]) begin
			kd_c = ktc_pkg::K_PROJECT; rs_c[5] = 1'b1;
		end else if (h[ktc_pkg::G_ROUTINE]) begin
			kd_c = ktc_pkg::K_ROUTINE; rs_c[6] = 1'b1;
		end else kd_c = ktc_pkg::K_NONE;
		if (h[ktc_pkg::G_EXPL]) begin
			rs_c[0] = 1'b1; or_c = ktc_pkg::ORG_EXPLICIT; ex_c = 1'b1;
		end else or_c = ktc_pkg::ORG_INFER;
		if (h[ktc_pkg::G_OTHER]) begin
			sc_c = h[ktc_pkg::G_SELF] ? ktc_pkg::SC_MIXED : ktc_pkg::SC_OTHER;
			rs_c[7] = 1'b1;
		end
		if (h[ktc_pkg::G_SENS]) begin sn_c = 1'b1; rs_c[8] = 1'b1; end
		if (confidence < {1'b0, min_conf_q}) rs_c[9] = 1'b1;
		ec_c = confidence[6:0];
		priority if (confidence > 8'd100) st_c = ktc_pkg::ST_BAD_CONF;
		else if (cnt_n > CW'(MAX_TEXT)) st_c = ktc_pkg::ST_TOO_LONG;
		else if (session_id == '0 || session_id != exp_sess_q) st_c = ktc_pkg::ST_BAD_SESS;
		else if (kd_c == ktc_pkg::K_NONE) st_c = ktc_pkg::ST_NO_CAND;
		else st_c = ktc_pkg::ST_OK;
		if (st_c != ktc_pkg::ST_OK) begin
			kd_c = ktc_pkg::K_NONE; or_c = ktc_pkg::ORG_NONE; rs_c = '0;
			sc_c = ktc_pkg::SC_SELF; sn_c = 1'b0; ex_c = 1'b0;
			ec_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (take && last_char) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take && last_char) begin
			status <= st_c; kind <= kd_c; origin <= or_c; reasons <= rs_c;
			{novelty, future_value, consequence} <= ktc_pkg::kind_defaults(kd_c);
			scope <= sc_c; sensitive <= sn_c; remember_req <= ex_c;
			confidence_echo <= ec_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tail_q <= 1'b0;
		else tail_q <= take && last_char;
	end

	`ASSERT_IMPL(a_res_after_last, clk, arst_n, (take && last_char) |=> out_valid)
	`ASSERT_NEVER(a_err_zero, clk, arst_n,
		out_valid && status != ktc_pkg::ST_OK && (kind != '0 || reasons != '0))
	`ASSERT_IMPL(a_cleared, clk, arst_n, tail_q |-> (count_q == '0 && hits_q == '0))
	`ASSERT_NEVER(a_ok_kind, clk, arst_n,
		out_valid && status == ktc_pkg::ST_OK && kind == ktc_pkg::K_NONE)
endmodule
`default_nettype wire
